### rtl/core/dtwr_pkg.sv
package dtwr_pkg;

   // Event kinds carried on the request tuser
   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_FRAME  = 2'd1,
      CMD_TXDONE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // Actions reported on the response tuser
   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_RESPONSE = 3'd1,
      ACT_INFO     = 3'd2,
      ACT_REARM    = 3'd3,
      ACT_ERROR    = 3'd4,
      ACT_TIMEOUT  = 3'd5
   } act_type;

   // Exchange state, one-hot
   typedef enum logic [2:0] {
      PH_IDLE       = 3'b001,
      PH_WAIT_TX    = 3'b010,
      PH_WAIT_FINAL = 3'b100
   } phase_type;

   // Register index, taken from paddr[4:2]
   typedef enum logic [2:0] {
      REG_NODE_ID       = 3'd0,
      REG_INITIATOR_ID  = 3'd1,
      REG_SINGLE_PAIR   = 3'd2,
      REG_DEBUG_TARGET  = 3'd3,
      REG_FINAL_TIMEOUT = 3'd4
   } reg_idx_type;

   localparam logic [7:0]  STAGE_POLL  = 8'd1;
   localparam logic [7:0]  STAGE_FINAL = 8'd3;

   localparam logic [7:0]  NODE_ID_RST       = 8'd2;
   localparam logic [7:0]  INITIATOR_ID_RST  = 8'd1;
   localparam logic        SINGLE_PAIR_RST   = 1'b0;
   localparam logic [7:0]  DEBUG_TARGET_RST  = 8'd2;
   localparam logic [15:0] FINAL_TIMEOUT_RST = 16'd250;

   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 72;

   typedef struct packed {
      logic [7:0]  node_id;
      logic [7:0]  initiator_id;
      logic        single_pair_mode;
      logic [7:0]  debug_target_id;
      logic [15:0] final_timeout_ticks;
   } cfg_type;

   // Only the low 32 bits of a timestamp reach any result
   typedef struct packed {
      cmd_type     cmd;
      logic        rx_ok;
      logic        error_frame;
      logic [7:0]  sender;
      logic [7:0]  destination;
      logic [7:0]  frame_stage;
      logic [31:0] ts_low;
   } item_type;

endpackage

### rtl/core/dtwr_csr.sv
module dtwr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dtwr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dtwr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dtwr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output dtwr_pkg::cfg_type                   cfg
);

   dtwr_pkg::cfg_type     cfg_ff;
   dtwr_pkg::cfg_type     cfg_in;
   dtwr_pkg::reg_idx_type idx;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign idx        = dtwr_pkg::reg_idx_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            dtwr_pkg::REG_NODE_ID:       cfg_in.node_id             = csr_pwdata[7:0];
            dtwr_pkg::REG_INITIATOR_ID:  cfg_in.initiator_id        = csr_pwdata[7:0];
            dtwr_pkg::REG_SINGLE_PAIR:   cfg_in.single_pair_mode    = csr_pwdata[0];
            dtwr_pkg::REG_DEBUG_TARGET:  cfg_in.debug_target_id     = csr_pwdata[7:0];
            dtwr_pkg::REG_FINAL_TIMEOUT: cfg_in.final_timeout_ticks = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_id             <= dtwr_pkg::NODE_ID_RST;
         cfg_ff.initiator_id        <= dtwr_pkg::INITIATOR_ID_RST;
         cfg_ff.single_pair_mode    <= dtwr_pkg::SINGLE_PAIR_RST;
         cfg_ff.debug_target_id     <= dtwr_pkg::DEBUG_TARGET_RST;
         cfg_ff.final_timeout_ticks <= dtwr_pkg::FINAL_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (idx)
         dtwr_pkg::REG_NODE_ID:       csr_prdata = {24'd0, cfg_ff.node_id};
         dtwr_pkg::REG_INITIATOR_ID:  csr_prdata = {24'd0, cfg_ff.initiator_id};
         dtwr_pkg::REG_SINGLE_PAIR:   csr_prdata = {31'd0, cfg_ff.single_pair_mode};
         dtwr_pkg::REG_DEBUG_TARGET:  csr_prdata = {24'd0, cfg_ff.debug_target_id};
         dtwr_pkg::REG_FINAL_TIMEOUT: csr_prdata = {16'd0, cfg_ff.final_timeout_ticks};
         default:                     csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/ds_twr_responder.sv
// Channel  | Dir | Handshake              | Payload
// req_     | in  | req_tvalid/req_tready  | tuser cmd; tdata events fields, 72 bits
// rsp_     | out | rsp_tvalid/rsp_tready  | tuser action; tdata peer, round, reply
// csr_     | in  | APB psel/penable       | 5 registers at 4*i, 32-bit data
//
// One beat per cycle sustained while rsp_ is not stalled; each request beat passes
// through the input register, then the result register loaded by the event decode.
// The exchange state updates in the same cycle as the result register, so the next
// beat always sees it. Reset is synchronous.
// A stalled rsp_ side holds its beat; the input register still takes one more
// request, after which req_tready follows rsp_tready.
module ds_twr_responder (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] rx_ok, [1] error_frame, [9:2] sender, [17:10] destination,
   // [25:18] frame_stage, [65:26] timestamp, [71:66] zero
   input  logic [dtwr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [1:0] cmd
   input  logic [1:0]                           req_tuser,
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] peer, [39:8] round_time, [71:40] reply_time
   output logic [dtwr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [2:0] action
   output logic [2:0]                           rsp_tuser,
   // configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dtwr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [dtwr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [dtwr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   dtwr_pkg::cfg_type   cfg;

   // input register
   logic                s1_valid_ff, s1_valid_in;
   dtwr_pkg::item_type  s1_item_ff, s1_item_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   dtwr_pkg::act_type   rsp_act_ff, rsp_act_in;
   logic [7:0]          rsp_peer_ff, rsp_peer_in;
   logic signed [31:0]  rsp_round_ff, rsp_round_in;
   logic signed [31:0]  rsp_reply_ff, rsp_reply_in;

   // exchange state
   dtwr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          peer_ff, peer_in;
   logic [31:0]         poll_rx_ff, poll_rx_in;
   logic [31:0]         resp_tx_ff, resp_tx_in;
   logic [31:0]         saved_reply_ff, saved_reply_in;
   logic [15:0]         wait_ff, wait_in;

   logic                req_fire;
   logic                out_free;
   logic                s1_fire;
   logic                blocked;

   dtwr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Flow control
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   // Unpack the request beat
   always_comb begin
      s1_item_in.cmd         = dtwr_pkg::cmd_type'(req_tuser);
      s1_item_in.rx_ok       = req_tdata[0];
      s1_item_in.error_frame = req_tdata[1];
      s1_item_in.sender      = req_tdata[9:2];
      s1_item_in.destination = req_tdata[17:10];
      s1_item_in.frame_stage = req_tdata[25:18];
      s1_item_in.ts_low      = req_tdata[57:26];
   end

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   assign blocked = cfg.single_pair_mode && (cfg.node_id != cfg.debug_target_id);

   // Decode one event against the exchange state
   always_comb begin
      rsp_act_in     = dtwr_pkg::ACT_NONE;
      rsp_peer_in    = 8'd0;
      rsp_round_in   = '0;
      rsp_reply_in   = '0;
      phase_in       = phase_ff;
      peer_in        = peer_ff;
      poll_rx_in     = poll_rx_ff;
      resp_tx_in     = resp_tx_ff;
      saved_reply_in = saved_reply_ff;
      wait_in        = wait_ff;
      if (!blocked) begin
         case (s1_item_ff.cmd)
            dtwr_pkg::CMD_TICK: begin
               if (phase_ff == dtwr_pkg::PH_WAIT_FINAL) begin
                  if (wait_ff >= cfg.final_timeout_ticks) begin
                     rsp_act_in  = dtwr_pkg::ACT_TIMEOUT;
                     rsp_peer_in = peer_ff;
                     phase_in    = dtwr_pkg::PH_IDLE;
                     peer_in     = 8'd0;
                     wait_in     = 16'd0;
                  end else begin
                     wait_in = 16'(wait_ff + 16'd1);
                  end
               end
            end
            dtwr_pkg::CMD_TXDONE: begin
               if (phase_ff == dtwr_pkg::PH_WAIT_TX) begin
                  resp_tx_in     = s1_item_ff.ts_low;
                  saved_reply_in = s1_item_ff.ts_low - poll_rx_ff;
                  phase_in       = dtwr_pkg::PH_WAIT_FINAL;
                  wait_in        = 16'd0;
               end
            end
            dtwr_pkg::CMD_FRAME: begin
               if (!s1_item_ff.rx_ok || s1_item_ff.error_frame) begin
                  rsp_act_in = dtwr_pkg::ACT_ERROR;
                  phase_in   = dtwr_pkg::PH_IDLE;
                  peer_in    = 8'd0;
                  wait_in    = 16'd0;
               end else if (s1_item_ff.destination != cfg.node_id) begin
                  rsp_act_in = dtwr_pkg::ACT_REARM;
               end else if (cfg.single_pair_mode &&
                            (s1_item_ff.sender != cfg.initiator_id)) begin
                  rsp_act_in = dtwr_pkg::ACT_REARM;
               end else begin
                  case (phase_ff)
                     dtwr_pkg::PH_IDLE: begin
                        if (s1_item_ff.frame_stage != dtwr_pkg::STAGE_POLL) begin
                           rsp_act_in = dtwr_pkg::ACT_REARM;
                        end else begin
                           rsp_act_in  = dtwr_pkg::ACT_RESPONSE;
                           rsp_peer_in = s1_item_ff.sender;
                           peer_in     = s1_item_ff.sender;
                           poll_rx_in  = s1_item_ff.ts_low;
                           phase_in    = dtwr_pkg::PH_WAIT_TX;
                        end
                     end
                     dtwr_pkg::PH_WAIT_FINAL: begin
                        if ((s1_item_ff.sender != peer_ff) ||
                            (s1_item_ff.frame_stage != dtwr_pkg::STAGE_FINAL)) begin
                           rsp_act_in = dtwr_pkg::ACT_ERROR;
                        end else begin
                           rsp_act_in   = dtwr_pkg::ACT_INFO;
                           rsp_peer_in  = peer_ff;
                           rsp_round_in = s1_item_ff.ts_low - resp_tx_ff;
                           rsp_reply_in = saved_reply_ff;
                        end
                        phase_in = dtwr_pkg::PH_IDLE;
                        peer_in  = 8'd0;
                        wait_in  = 16'd0;
                     end
                     default: begin
                        // frame while the response is still going out
                        rsp_act_in = dtwr_pkg::ACT_ERROR;
                        phase_in   = dtwr_pkg::PH_IDLE;
                        peer_in    = 8'd0;
                        wait_in    = 16'd0;
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= dtwr_pkg::PH_IDLE;
         peer_ff      <= 8'd0;
         wait_ff      <= 16'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            phase_ff <= phase_in;
            peer_ff  <= peer_in;
            wait_ff  <= wait_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= s1_item_in;
      end
      if (s1_fire) begin
         rsp_act_ff     <= rsp_act_in;
         rsp_peer_ff    <= rsp_peer_in;
         rsp_round_ff   <= rsp_round_in;
         rsp_reply_ff   <= rsp_reply_in;
         poll_rx_ff     <= poll_rx_in;
         resp_tx_ff     <= resp_tx_in;
         saved_reply_ff <= saved_reply_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_reply_ff, rsp_round_ff, rsp_peer_ff};
   assign rsp_tuser  = rsp_act_ff;

   // Times are only reported with ranging info
   a_times_only_info: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_act_ff != dtwr_pkg::ACT_INFO)) |->
      ((rsp_round_ff == 32'sd0) && (rsp_reply_ff == 32'sd0)))
      else $error("round or reply time set on a non-info result");

   // A response request leaves the exchange waiting for transmit done
   a_resp_wait_tx: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (rsp_act_in == dtwr_pkg::ACT_RESPONSE)) |=>
      (phase_ff == dtwr_pkg::PH_WAIT_TX))
      else $error("response sent without entering wait for transmit done");

   // Backpressure only while the input register holds a beat
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff)
      else $error("request stalled with empty input register");

   // A held beat in the input register stays put until it moves on
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("input register lost a stalled beat");

   // Info results carry the stored peer and leave the exchange idle, with peer and wait cleared
   a_info_from_final: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (rsp_act_in == dtwr_pkg::ACT_INFO)) |=>
      ((phase_ff == dtwr_pkg::PH_IDLE) && (peer_ff == 8'd0) && (wait_ff == 16'd0)))
      else $error("exchange not closed after ranging info");

endmodule
